### hdl/mbrd_pkg.sv
`default_nettype none

package mbrd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;
    localparam logic [6:0] FUNC_CODE_RESET  = 7'd3;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_FUNC_CODE  = 1'b1;

    localparam logic [7:0] WRITE_BODY_LEN = 8'd4;
    localparam logic [7:0] EXC_BODY_LEN   = 8'd1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_EXC     = 2'd2,
        KIND_BADCRC  = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        PH_HUNT      = 7'b0000001,
        PH_FUNC      = 7'b0000010,
        PH_COUNT     = 7'b0000100,
        PH_READ_DATA = 7'b0001000,
        PH_FIXED     = 7'b0010000,
        PH_CRC_LO    = 7'b0100000,
        PH_CRC_HI    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] exception_code;
        logic [7:0] payload_count;
    } result_t;

    // Modbus CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic is_read_code(input logic [6:0] fc);
        logic r;
        case (fc) inside
            7'd1, 7'd2, 7'd3, 7'd4: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_write_code(input logic [6:0] fc);
        logic r;
        case (fc) inside
            7'd5, 7'd6, 7'd15, 7'd16: r = 1'b1;
            default:                  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/modbus_rtu_response_deframer.sv
// A byte in the input register feeds the frame logic, whose result is registered at the output.
// Throughput: one byte per cycle; a stall on the output backs up through the two registers.
// The CRC-16 byte update is evaluated combinationally between the input and result registers.
// Reset (rst_n, asynchronous, active low): both stages empty, hunting for address, CRC 0xFFFF,
// slave address 1, function code 3.
`default_nettype none

module modbus_rtu_response_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel: index 0 slave_address, 1 function_code
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    // received byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] data_byte, [15:8] exception_code,
                                        // [23:16] payload_count
    output logic [1:0]       m_tuser    // [1:0] kind
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              out_ready;
    logic              step;
    mbrd_pkg::result_t result;

    // Configuration is always taken; write it only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    // Advance the held byte whenever the result register can take a transaction,
    // whether or not this byte produces one.
    assign step = byte_valid && out_ready;

    mbrd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Frame tracking: address hunt, function check, length, CRC compare.
    mbrd_frame_fsm u_frame_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .rx_byte   (byte_data),
        .result    (result)
    );

    // Hold each result until the downstream side takes it.
    mbrd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### hdl/mbrd_in_stage.sv
`default_nettype none

module mbrd_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // take a new byte when empty or when the held byte is consumed this cycle
    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

### hdl/mbrd_frame_fsm.sv
`default_nettype none

module mbrd_frame_fsm
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    output mbrd_pkg::result_t  result
);

    logic [7:0]       slave_addr_reg;
    logic [6:0]       func_code_reg;

    mbrd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic             exc_seen_reg, exc_seen_next;
    logic [7:0]       exc_code_reg, exc_code_next;

    logic [15:0]      crc_upd;
    logic [7:0]       left_dec;
    logic             supported;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= mbrd_pkg::SLAVE_ADDR_RESET;
            func_code_reg  <= mbrd_pkg::FUNC_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mbrd_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data;
                mbrd_pkg::CFG_FUNC_CODE:  func_code_reg  <= cfg_data[6:0];
                default:                  ;
            endcase
        end
    end

    assign crc_upd   = mbrd_pkg::crc_byte(crc_reg, rx_byte);
    assign left_dec  = left_reg - 8'd1;
    assign supported = mbrd_pkg::is_read_code(func_code_reg)
                       || mbrd_pkg::is_write_code(func_code_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        left_next     = left_reg;
        count_next    = count_reg;
        crc_lo_next   = crc_lo_reg;
        exc_seen_next = exc_seen_reg;
        exc_code_next = exc_code_reg;
        result        = '0;

        unique case (phase_reg)
            mbrd_pkg::PH_FUNC:
            begin
                if (supported && rx_byte == {1'b0, func_code_reg})
                begin
                    crc_next = crc_upd;
                    if (mbrd_pkg::is_read_code(func_code_reg))
                    begin
                        phase_next = mbrd_pkg::PH_COUNT;
                    end
                    else
                    begin
                        left_next  = mbrd_pkg::WRITE_BODY_LEN;
                        phase_next = mbrd_pkg::PH_FIXED;
                    end
                end
                else if (supported && rx_byte == {1'b1, func_code_reg})
                begin
                    crc_next      = crc_upd;
                    exc_seen_next = 1'b1;
                    left_next     = mbrd_pkg::EXC_BODY_LEN;
                    phase_next    = mbrd_pkg::PH_FIXED;
                end
                else
                begin
                    // retry the byte as an address
                    left_next     = '0;
                    count_next    = '0;
                    crc_lo_next   = '0;
                    exc_seen_next = 1'b0;
                    exc_code_next = '0;
                    if (rx_byte == slave_addr_reg)
                    begin
                        crc_next   = mbrd_pkg::crc_byte(mbrd_pkg::CRC_INIT, rx_byte);
                        phase_next = mbrd_pkg::PH_FUNC;
                    end
                    else
                    begin
                        crc_next   = mbrd_pkg::CRC_INIT;
                        phase_next = mbrd_pkg::PH_HUNT;
                    end
                end
            end
            mbrd_pkg::PH_COUNT:
            begin
                crc_next   = crc_upd;
                count_next = rx_byte;
                left_next  = rx_byte;
                phase_next = (rx_byte == 8'd0) ? mbrd_pkg::PH_CRC_LO
                                               : mbrd_pkg::PH_READ_DATA;
            end
            mbrd_pkg::PH_READ_DATA:
            begin
                crc_next  = crc_upd;
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    phase_next = mbrd_pkg::PH_CRC_LO;
                end
                result.valid     = 1'b1;
                result.kind      = mbrd_pkg::KIND_PAYLOAD;
                result.data_byte = rx_byte;
            end
            mbrd_pkg::PH_FIXED:
            begin
                crc_next  = crc_upd;
                left_next = left_dec;
                if (exc_seen_reg)
                begin
                    exc_code_next = rx_byte;
                end
                if (left_dec == 8'd0)
                begin
                    phase_next = mbrd_pkg::PH_CRC_LO;
                end
            end
            mbrd_pkg::PH_CRC_LO:
            begin
                crc_lo_next = rx_byte;
                phase_next  = mbrd_pkg::PH_CRC_HI;
            end
            mbrd_pkg::PH_CRC_HI:
            begin
                result.valid = 1'b1;
                if ({rx_byte, crc_lo_reg} != crc_reg)
                begin
                    result.kind          = mbrd_pkg::KIND_BADCRC;
                    result.payload_count = count_reg;
                end
                else if (exc_seen_reg)
                begin
                    result.kind           = mbrd_pkg::KIND_EXC;
                    result.exception_code = exc_code_reg;
                end
                else
                begin
                    result.kind          = mbrd_pkg::KIND_GOOD;
                    result.payload_count = count_reg;
                end
                // frame done, hunt from the next byte
                phase_next    = mbrd_pkg::PH_HUNT;
                crc_next      = mbrd_pkg::CRC_INIT;
                left_next     = '0;
                count_next    = '0;
                crc_lo_next   = '0;
                exc_seen_next = 1'b0;
                exc_code_next = '0;
            end
            default:
            begin
                // hunting, and any stray phase code
                left_next     = '0;
                count_next    = '0;
                crc_lo_next   = '0;
                exc_seen_next = 1'b0;
                exc_code_next = '0;
                if (rx_byte == slave_addr_reg)
                begin
                    crc_next   = mbrd_pkg::crc_byte(mbrd_pkg::CRC_INIT, rx_byte);
                    phase_next = mbrd_pkg::PH_FUNC;
                end
                else
                begin
                    crc_next   = mbrd_pkg::CRC_INIT;
                    phase_next = mbrd_pkg::PH_HUNT;
                end
            end
        endcase

        if (!step)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mbrd_pkg::PH_HUNT;
            crc_reg      <= mbrd_pkg::CRC_INIT;
            left_reg     <= '0;
            count_reg    <= '0;
            crc_lo_reg   <= '0;
            exc_seen_reg <= 1'b0;
            exc_code_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            left_reg     <= left_next;
            count_reg    <= count_next;
            crc_lo_reg   <= crc_lo_next;
            exc_seen_reg <= exc_seen_next;
            exc_code_reg <= exc_code_next;
        end
    end

endmodule

`default_nettype wire

### hdl/mbrd_out_stage.sv
`default_nettype none

module mbrd_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbrd_pkg::result_t result,
    output logic                   ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,
    output logic [1:0]             m_tuser
);

    logic         valid_reg;
    logic [1:0]   kind_reg;
    logic [23:0]  data_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && result.valid)
        begin
            kind_reg <= result.kind;
            data_reg <= {result.payload_count, result.exception_code, result.data_byte};
        end
    end

endmodule

`default_nettype wire

### sim/mbrd_frame_checker.sv
`timescale 1ns / 100ps

module mbrd_frame_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] exception_code,
                                        // [23:16] payload_count
    input  wire logic [1:0]  m_tuser,   // [1:0] kind
    output int               fail_count,
    output int               pending,
    output int               payload_seen,
    output int               verdicts_seen
);

    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [6:0] FC_READ_FIRST = 7'd1;
    localparam logic [6:0] FC_READ_LAST  = 7'd4;
    localparam logic [6:0] FC_WR_COIL    = 7'd5;
    localparam logic [6:0] FC_WR_REG     = 7'd6;
    localparam logic [6:0] FC_WR_COILS   = 7'd15;
    localparam logic [6:0] FC_WR_REGS    = 7'd16;

    typedef struct packed {
        mbrd_pkg::kind_t kind;
        logic [7:0]      data_byte;
        logic [7:0]      exception_code;
        logic [7:0]      payload_count;
    } frame_result_t;

    frame_result_t due_q[$];
    frame_result_t head;

    // shadow registers and deframer state
    logic [7:0]       want_addr;
    logic [6:0]       want_fc;
    mbrd_pkg::phase_t phase;
    logic [15:0]      crc_acc;
    logic [7:0]       body_left;
    logic [7:0]       count_byte;
    logic [7:0]       crc_low;
    logic             in_exception;
    logic [7:0]       exc_byte;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        payload_seen  = 0;
        verdicts_seen = 0;
    end

    // bitwise reflected CRC-16, data LSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ mbrd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_hunt();
        phase        = mbrd_pkg::PH_HUNT;
        crc_acc      = mbrd_pkg::CRC_INIT;
        body_left    = '0;
        count_byte   = '0;
        crc_low      = '0;
        in_exception = 1'b0;
        exc_byte     = '0;
    endtask

    task automatic test_address(input logic [7:0] b);
        restart_hunt();
        if (b == want_addr)
        begin
            crc_acc = crc16_step(mbrd_pkg::CRC_INIT, b);
            phase   = mbrd_pkg::PH_FUNC;
        end
    endtask

    task automatic post(input mbrd_pkg::kind_t k, input logic [7:0] d, input logic [7:0] e,
                        input logic [7:0] c);
        due_q.push_back('{kind: k, data_byte: d, exception_code: e, payload_count: c});
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic rd;
        logic wr;
        rd = (want_fc >= FC_READ_FIRST) && (want_fc <= FC_READ_LAST);
        wr = want_fc inside {FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
        case (phase)
            mbrd_pkg::PH_FUNC:
            begin
                if ((rd || wr) && b == {1'b0, want_fc})
                begin
                    crc_acc = crc16_step(crc_acc, b);
                    if (rd)
                    begin
                        phase = mbrd_pkg::PH_COUNT;
                    end
                    else
                    begin
                        body_left = mbrd_pkg::WRITE_BODY_LEN;
                        phase     = mbrd_pkg::PH_FIXED;
                    end
                end
                else if ((rd || wr) && b == ({1'b0, want_fc} | EXC_FLAG))
                begin
                    crc_acc      = crc16_step(crc_acc, b);
                    in_exception = 1'b1;
                    body_left    = mbrd_pkg::EXC_BODY_LEN;
                    phase        = mbrd_pkg::PH_FIXED;
                end
                else
                begin
                    // a wrong function byte may itself open a frame
                    test_address(b);
                end
            end
            mbrd_pkg::PH_COUNT:
            begin
                crc_acc    = crc16_step(crc_acc, b);
                count_byte = b;
                body_left  = b;
                phase      = (b == 8'd0) ? mbrd_pkg::PH_CRC_LO : mbrd_pkg::PH_READ_DATA;
            end
            mbrd_pkg::PH_READ_DATA:
            begin
                crc_acc   = crc16_step(crc_acc, b);
                body_left = body_left - 8'd1;
                if (body_left == 8'd0)
                begin
                    phase = mbrd_pkg::PH_CRC_LO;
                end
                post(mbrd_pkg::KIND_PAYLOAD, b, 8'd0, 8'd0);
            end
            mbrd_pkg::PH_FIXED:
            begin
                crc_acc = crc16_step(crc_acc, b);
                if (in_exception)
                begin
                    exc_byte = b;
                end
                body_left = body_left - 8'd1;
                if (body_left == 8'd0)
                begin
                    phase = mbrd_pkg::PH_CRC_LO;
                end
            end
            mbrd_pkg::PH_CRC_LO:
            begin
                crc_low = b;
                phase   = mbrd_pkg::PH_CRC_HI;
            end
            mbrd_pkg::PH_CRC_HI:
            begin
                if ({b, crc_low} != crc_acc)
                begin
                    post(mbrd_pkg::KIND_BADCRC, 8'd0, 8'd0, count_byte);
                end
                else if (in_exception)
                begin
                    post(mbrd_pkg::KIND_EXC, 8'd0, exc_byte, 8'd0);
                end
                else
                begin
                    post(mbrd_pkg::KIND_GOOD, 8'd0, 8'd0, count_byte);
                end
                restart_hunt();
            end
            default:
            begin
                test_address(b);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_addr = mbrd_pkg::SLAVE_ADDR_RESET;
            want_fc   = mbrd_pkg::FUNC_CODE_RESET;
            restart_hunt();
            due_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (m_tuser == mbrd_pkg::KIND_PAYLOAD)
                begin
                    payload_seen++;
                end
                else
                begin
                    verdicts_seen++;
                end
                if (due_q.size() == 0)
                begin
                    $error("result transaction with none due: kind %0d tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    head = due_q.pop_front();
                    if (m_tuser != head.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", head.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] != head.data_byte)
                    begin
                        $error("data_byte: expected %h, actual %h",
                               head.data_byte, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[15:8] != head.exception_code)
                    begin
                        $error("exception_code: expected %h, actual %h",
                               head.exception_code, m_tdata[15:8]);
                        fail_count++;
                    end
                    if (m_tdata[23:16] != head.payload_count)
                    begin
                        $error("payload_count: expected %0d, actual %0d",
                               head.payload_count, m_tdata[23:16]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mbrd_pkg::CFG_SLAVE_ADDR)
                begin
                    want_addr = cfg_data;
                end
                else
                begin
                    want_fc = cfg_data[6:0];
                end
            end
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata);
            end
            pending = due_q.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_BYTES = 1400;     // received bytes in the random part
    localparam int PHASE_BYTES  = 140;      // bytes sent under one register setting
    localparam int NUM_PHASES   = 10;
    localparam int LIMIT_CYCLES = 400000;   // several times the slowest legal run
    localparam int LONG_HOLD    = 300;      // long output stall, in cycles
    localparam int SETTLE       = 4;        // pipeline is two stages deep
    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [6:0] FC_READ_LAST  = 7'd4;
    localparam logic [6:0] FC_WRITE_LAST = 7'd16;

    // Function code per register setting; zero in this plan means draw one at random.
    // The plan covers every read and write code, the top of the range (unsupported)
    // and ends back on the reset code.
    localparam logic [6:0] FC_PLAN [NUM_PHASES] =
        '{7'd1, 7'd16, 7'd2, 7'd4, 7'd5, 7'd6, 7'd15, 7'd127, 7'd0, 7'd3};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = mbrd_pkg::CFG_SLAVE_ADDR;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int payload_seen;
    int verdicts_seen;

    int          bytes_sent  = 0;
    int          cfg_writes  = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;    // both sides run without gaps
    bit          hold_req    = 1'b0;    // ask the receiver for one long stall
    bit          big_pending = 1'b0;    // next read frame carries 255 payload bytes
    logic [7:0]  cur_addr    = mbrd_pkg::SLAVE_ADDR_RESET;
    logic [6:0]  cur_fc      = mbrd_pkg::FUNC_CODE_RESET;
    logic [7:0]  frame_q[$];            // bytes of the frame under construction

    modbus_rtu_response_deframer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mbrd_frame_checker frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .payload_seen  (payload_seen),
        .verdicts_seen (verdicts_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: count cycles and end the run if it hangs.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results still due", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: draw a stall before every result transaction, and honor one
    // long hold-off so the block backs up and drops s_tready.
    initial
    begin
        int gap;
        int held;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Offer one byte after a random gap; return at the falling edge after the transaction.
    // Leave tvalid high so back-to-back bytes need no second assignment in one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // Drop tvalid, wait for every due result, then let the last byte clear the pipeline.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; keep cfg_valid high when another write follows.
    task automatic write_reg(input logic idx, input logic [7:0] val, input bit close);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (close)
        begin
            cfg_valid <= 1'b0;
        end
        cfg_writes++;
    endtask

    task automatic open_frame(input logic [7:0] a, input logic [7:0] f);
        frame_q.delete();
        frame_q.push_back(a);
        frame_q.push_back(f);
    endtask

    // Append the CRC, low byte first; flip one CRC bit for a corrupted frame.
    task automatic close_frame(input bit corrupt);
        logic [15:0] c;
        c = mbrd_pkg::CRC_INIT;
        foreach (frame_q[i])
        begin
            c = mbrd_pkg::crc_byte(c, frame_q[i]);
        end
        if (corrupt)
        begin
            c = c ^ (16'd1 << $urandom_range(0, 15));
        end
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic ship_frame(input int upto);
        for (int i = 0; i < upto; i++)
        begin
            send_byte(frame_q[i]);
        end
    endtask

    // Mostly well-formed frames for the current setting with random content;
    // the rest is line noise, foreign addresses, wrong codes, bad CRCs and
    // frames cut short.
    task automatic random_frame();
        int         sel;
        int         n;
        int         cut;
        logic [7:0] a;
        logic [7:0] f;
        bit         as_exc;
        bit         as_read;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        a = cur_addr;
        f = {1'b0, cur_fc};
        if (sel < 15)
        begin
            a = cur_addr ^ (8'd1 << $urandom_range(0, 7));
        end
        as_exc  = ($urandom_range(0, 4) == 0);
        as_read = (cur_fc <= FC_READ_LAST) ||
                  (cur_fc > FC_WRITE_LAST && $urandom_range(0, 1) == 1);
        if (as_exc)
        begin
            f = f | EXC_FLAG;
        end
        if (sel >= 15 && sel < 20)
        begin
            f = 8'($urandom_range(0, 255));
        end
        open_frame(a, f);
        if (as_exc)
        begin
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (as_read)
        begin
            if (big_pending)
            begin
                n = 255;
                big_pending = 1'b0;
            end
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            end
            frame_q.push_back(8'(n));
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (mbrd_pkg::WRITE_BODY_LEN) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        close_frame(sel >= 90);
        cut = (sel >= 85 && sel < 90) ? $urandom_range(1, 3) : 0;
        ship_frame(frame_q.size() - cut);
    endtask

    initial
    begin
        int         p;
        int         phase_end;
        int         target;
        logic [7:0] na;
        logic [6:0] nf;

        // Hold reset low, then release it on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset setting (address 1, read holding registers).
        // Read frame carrying both payload extremes.
        open_frame(cur_addr, {1'b0, cur_fc});
        frame_q.push_back(8'd2);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        close_frame(1'b0);
        ship_frame(frame_q.size());
        // Function byte that is really the address: restart there, then a zero-count read.
        send_byte(cur_addr);
        open_frame(cur_addr, {1'b0, cur_fc});
        frame_q.push_back(8'd0);
        close_frame(1'b0);
        ship_frame(frame_q.size());
        // Function byte matching nothing: back to hunting, then an exception frame.
        send_byte(cur_addr);
        send_byte(8'h07);
        open_frame(cur_addr, {1'b0, cur_fc} | EXC_FLAG);
        frame_q.push_back(8'hFF);
        close_frame(1'b0);
        ship_frame(frame_q.size());
        // CRC mismatch yields a bad-CRC verdict for the frame.
        open_frame(cur_addr, {1'b0, cur_fc});
        frame_q.push_back(8'd0);
        close_frame(1'b1);
        ship_frame(frame_q.size());

        // Change the function code in the middle of a write frame: the code
        // latched on the function byte must still govern the frame.
        wait_idle();
        cur_fc = 7'd6;
        write_reg(mbrd_pkg::CFG_FUNC_CODE, {1'b0, cur_fc}, 1'b1);
        open_frame(cur_addr, {1'b0, cur_fc});
        frame_q.push_back(8'hAA);
        frame_q.push_back(8'h55);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        close_frame(1'b0);
        ship_frame(4);
        wait_idle();
        cur_fc = mbrd_pkg::FUNC_CODE_RESET;
        write_reg(mbrd_pkg::CFG_FUNC_CODE, {1'b0, cur_fc}, 1'b1);
        for (int i = 4; i < frame_q.size(); i++)
        begin
            send_byte(frame_q[i]);
        end

        // Random part: step through register settings, extremes first.
        target = bytes_sent + RANDOM_BYTES;
        for (p = 0; bytes_sent < target; p++)
        begin
            wait_idle();
            case (p % NUM_PHASES)
                0:       na = 8'h00;
                1:       na = 8'hFF;
                7:       na = 8'h80;
                default: na = 8'($urandom_range(0, 255));
            endcase
            nf = FC_PLAN[p % NUM_PHASES];
            if (nf == 7'd0)
            begin
                nf = 7'($urandom_range(1, 127));
            end
            write_reg(mbrd_pkg::CFG_SLAVE_ADDR, na, 1'b0);
            write_reg(mbrd_pkg::CFG_FUNC_CODE, {1'b0, nf}, 1'b1);
            cur_addr = na;
            cur_fc   = nf;
            steady      = ($urandom_range(0, 3) == 0);
            big_pending = (p == 0);
            if (p == 2)
            begin
                // Stall the output for a long stretch while bytes keep coming.
                hold_req = 1'b1;
                steady   = 1'b1;
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                random_frame();
            end
        end

        // Drain, give the pipeline time to show anything stray, then report.
        wait_idle();
        repeat (2 * SETTLE) @(posedge clk);
        $display("Sent %0d bytes under %0d register writes, including a %0d-cycle output stall.",
                 bytes_sent, cfg_writes, LONG_HOLD);
        $display("Checked %0d payload bytes and %0d frame verdicts; %0d mismatches.",
                 payload_seen, verdicts_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mbrd_pkg.sv
hdl/mbrd_in_stage.sv
hdl/mbrd_frame_fsm.sv
hdl/mbrd_out_stage.sv
hdl/modbus_rtu_response_deframer.sv
sim/mbrd_frame_checker.sv
sim/tb.sv
